// File: src/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame parser.
// No dependencies; used by the event channel interface and the top level.
package wsfp_pkg;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_CLOSE   = 2'd2,
        EV_ABORT   = 2'd3
    } event_kind_t;

    localparam logic [3:0]  OP_CLOSE   = 4'h8;
    localparam logic [15:0] NO_STATUS  = 16'd1005;
    localparam logic [6:0]  LEN7_EXT16 = 7'd126;
    localparam logic [6:0]  LEN7_EXT64 = 7'd127;

endpackage

// File: src/wsfp_in_if.sv
// Receive byte channel: valid/ready plus one buffer byte and its end mark.
// Stand-alone; no package dependency.
interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// File: src/wsfp_out_if.sv
// Parser event channel: valid/ready plus one parsed event.
// Depends on wsfp_pkg for the event kind type.
interface wsfp_out_if;
    logic                 valid;
    logic                 ready;
    wsfp_pkg::event_kind_t event_kind;
    logic [7:0]           data_byte;
    logic [3:0]           frame_opcode;
    logic                 last_byte;
    logic [15:0]          status_code;

    modport source (output valid, output event_kind, output data_byte, output frame_opcode,
                    output last_byte, output status_code, input ready);
    modport sink   (input valid, input event_kind, input data_byte, input frame_opcode,
                    input last_byte, input status_code, output ready);
endinterface

// File: src/websocket_frame_parser_unit.sv
// WebSocket (RFC 6455) frame parser top level.
// Depends on wsfp_pkg, wsfp_in_if and wsfp_out_if.

// Takes one received byte per transfer and parses one frame per receive
// buffer (buffer_end marks the buffer's last byte). Every byte is handled in
// the cycle it is taken: the parse state and a single result register are
// updated at that edge, so a byte can be taken every cycle and its event (if
// any) is offered on the next cycle. At most one event results from a byte.
// The input is ready whenever the result register is empty or its event is
// being taken in the same cycle, so throughput is one byte per cycle as long
// as the event sink keeps up; a stalled sink holds the input only while an
// event is actually waiting. Event kinds: payload byte (unmasked, with the
// opcode and a last-byte mark), empty message, close request (status code,
// or 1005 if the payload carries fewer than two bytes) and abort, given when
// a buffer ends before its frame is complete. FIN and RSV bits are ignored;
// any opcode other than close is treated as data. Bytes after a complete
// frame are dropped until the buffer ends. Extended lengths wider than
// LENGTH_BITS saturate to all ones.
module websocket_frame_parser_unit #(
    parameter int LENGTH_BITS = 64    // 16..64
) (
    input  logic              clk,
    input  logic              rst_n,
    wsfp_in_if.sink           rx,
    wsfp_out_if.source        ev
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    // parse state
    phase_t                 phase_reg,   phase_next;
    logic [3:0]             opcode_reg,  opcode_next;
    logic                   mask_reg,    mask_next;
    logic                   long_reg,    long_next;     // 64-bit extended length
    logic [2:0]             hbc_reg,     hbc_next;
    logic [LENGTH_BITS-1:0] rem_reg,     rem_next;
    logic [31:0]            key_reg,     key_next;
    logic [1:0]             pos_reg,     pos_next;
    logic [15:0]            cacc_reg,    cacc_next;
    logic [1:0]             cseen_reg,   cseen_next;

    // result register
    logic                   out_valid_reg;
    wsfp_pkg::event_kind_t  kind_reg;
    logic [7:0]             data_reg;
    logic [3:0]             evop_reg;
    logic                   last_reg;
    logic [15:0]            code_reg;

    // result of the byte being taken
    logic                   res_valid;
    wsfp_pkg::event_kind_t  res_kind;
    logic [7:0]             res_data;
    logic                   res_last;
    logic [15:0]            res_code;

    logic                   take;
    logic                   len_done;
    logic                   hdr_done;
    logic [2:0]             hbc_inc;
    logic [7:0]             key_byte;
    logic [7:0]             plain;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   pay_last;

    assign rx.ready = !out_valid_reg || ev.ready;
    assign take     = rx.valid && rx.ready;

    assign hbc_inc  = hbc_reg + 3'd1;
    // key bytes are used most significant first
    assign key_byte = key_reg[{~pos_reg, 3'b000} +: 8];
    assign plain    = rx.rx_byte ^ (mask_reg ? key_byte : 8'h00);
    assign rem_dec  = rem_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign pay_last = (rem_dec == '0);

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        long_next   = long_reg;
        hbc_next    = hbc_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        cacc_next   = cacc_reg;
        cseen_next  = cseen_reg;
        res_valid   = 1'b0;
        res_kind    = wsfp_pkg::EV_PAYLOAD;
        res_data    = 8'h00;
        res_last    = 1'b0;
        res_code    = 16'h0000;
        len_done    = 1'b0;
        hdr_done    = 1'b0;

        case (phase_reg)
            PH_HDR0:
            begin
                opcode_next = rx.rx_byte[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = rx.rx_byte[7];
                hbc_next  = 3'd0;
                rem_next  = '0;
                if (rx.rx_byte[6:0] == wsfp_pkg::LEN7_EXT16)
                begin
                    long_next  = 1'b0;
                    phase_next = PH_EXTLEN;
                end
                else if (rx.rx_byte[6:0] == wsfp_pkg::LEN7_EXT64)
                begin
                    long_next  = 1'b1;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    rem_next = {{(LENGTH_BITS-7){1'b0}}, rx.rx_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                // saturate once the top byte is occupied
                if (rem_reg[LENGTH_BITS-1 -: 8] != 8'h00)
                    rem_next = '1;
                else
                    rem_next = {rem_reg[LENGTH_BITS-9:0], rx.rx_byte};
                hbc_next = hbc_inc;
                // eight bytes wrap the 3-bit count back to zero
                if (long_reg ? (hbc_inc == 3'd0) : (hbc_inc == 3'd2))
                    len_done = 1'b1;
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], rx.rx_byte};
                hbc_next = hbc_inc;
                if (hbc_inc == 3'd4)
                begin
                    hbc_next = 3'd0;
                    hdr_done = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                pos_next = pos_reg + 2'd1;
                rem_next = rem_dec;
                if (opcode_reg == wsfp_pkg::OP_CLOSE)
                begin
                    if (cseen_reg < 2'd2)
                    begin
                        cacc_next  = {cacc_reg[7:0], plain};
                        cseen_next = cseen_reg + 2'd1;
                    end
                    if (pay_last)
                    begin
                        res_valid = 1'b1;
                        res_kind  = wsfp_pkg::EV_CLOSE;
                        res_code  = (cseen_next == 2'd2) ? cacc_next : wsfp_pkg::NO_STATUS;
                    end
                end
                else
                begin
                    res_valid = 1'b1;
                    res_kind  = wsfp_pkg::EV_PAYLOAD;
                    res_data  = plain;
                    res_last  = pay_last;
                end
                if (pay_last)
                    phase_next = PH_DISCARD;
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase

        // length complete: masking key next, or header complete
        if (len_done)
        begin
            hbc_next = 3'd0;
            if (mask_next)
            begin
                key_next   = 32'h0;
                phase_next = PH_MASK;
            end
            else
                hdr_done = 1'b1;
        end

        if (hdr_done)
        begin
            pos_next   = 2'd0;
            cacc_next  = 16'h0000;
            cseen_next = 2'd0;
            if (rem_next == '0)
            begin
                phase_next = PH_DISCARD;
                res_valid  = 1'b1;
                if (opcode_next == wsfp_pkg::OP_CLOSE)
                begin
                    res_kind = wsfp_pkg::EV_CLOSE;
                    res_code = wsfp_pkg::NO_STATUS;
                end
                else
                    res_kind = wsfp_pkg::EV_EMPTY;
            end
            else
                phase_next = PH_PAYLOAD;
        end

        // buffer end: abort an unfinished frame, then restart
        if (rx.buffer_end)
        begin
            if (phase_next != PH_DISCARD)
            begin
                res_valid = 1'b1;
                res_kind  = wsfp_pkg::EV_ABORT;
                res_data  = 8'h00;
                res_last  = 1'b0;
                res_code  = 16'h0000;
            end
            phase_next = PH_HDR0;
            hbc_next   = 3'd0;
        end
    end

    // parse state and result register; the result payload is loaded with
    // every transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= 4'h0;
            mask_reg      <= 1'b0;
            long_reg      <= 1'b0;
            hbc_reg       <= 3'd0;
            rem_reg       <= '0;
            key_reg       <= 32'h0;
            pos_reg       <= 2'd0;
            cacc_reg      <= 16'h0000;
            cseen_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            kind_reg      <= wsfp_pkg::EV_PAYLOAD;
            data_reg      <= 8'h00;
            evop_reg      <= 4'h0;
            last_reg      <= 1'b0;
            code_reg      <= 16'h0000;
        end
        else
        begin
            if (take)
            begin
                phase_reg     <= phase_next;
                opcode_reg    <= opcode_next;
                mask_reg      <= mask_next;
                long_reg      <= long_next;
                hbc_reg       <= hbc_next;
                rem_reg       <= rem_next;
                key_reg       <= key_next;
                pos_reg       <= pos_next;
                cacc_reg      <= cacc_next;
                cseen_reg     <= cseen_next;
                out_valid_reg <= res_valid;
                kind_reg      <= res_kind;
                data_reg      <= res_data;
                evop_reg      <= opcode_next;
                last_reg      <= res_last;
                code_reg      <= res_code;
            end
            else if (ev.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign ev.valid        = out_valid_reg;
    assign ev.event_kind   = kind_reg;
    assign ev.data_byte    = data_reg;
    assign ev.frame_opcode = evop_reg;
    assign ev.last_byte    = last_reg;
    assign ev.status_code  = code_reg;

`ifndef SYNTHESIS
    // payload phase always has at least one byte left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with zero remaining length");

    // masking key is at most four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MASK |-> hbc_reg[2] == 1'b0)
        else $error("masking key count overrun");

    // a buffer end always returns the parser to the first header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        take && rx.buffer_end |=> phase_reg == PH_HDR0)
        else $error("parser not restarted after buffer end");

    // last-byte mark only on payload byte events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> kind_reg == wsfp_pkg::EV_PAYLOAD)
        else $error("last-byte mark on non-payload event");
`endif

endmodule
